// File: sv/cgen_pkg.sv
// Shared package for the combination tuple generator.
// Field widths, function and register codes, cell control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cgen_pkg;

  localparam int POS_W          = 13;   // position register width
  localparam int VAR_W          = 16;   // emitted variable width
  localparam int K_W            = 4;    // tuple size register width
  localparam int N_W            = 13;   // variable count register width
  localparam int IDX_W          = 12;   // map index field width
  localparam int FUNC_W         = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;
  localparam int NUM_VARS_OUT   = 8;    // var_0 .. var_7 ports
  localparam int J_W            = 3;    // slot counter over the var ports
  localparam int DEF_MAX_DIM    = 8;
  localparam int DEF_MAX_VARS   = 4096;

  localparam logic [FUNC_W-1:0] FUNC_RESTART  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_MAP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EMIT     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_DIMS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_MAP     = 2'd2;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic           restart;   // reload position with its own index
    logic [N_W-1:0] nk;        // effective n minus effective k
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: sv/cgen_cell.sv
// One position cell of the generator chain.
// Holds one position; passes the carry token left and the refill token right.
// Depends on cgen_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cgen_cell import cgen_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic             active,
  input  wire logic             carry_in,
  input  wire logic             fill_in,
  input  wire logic [POS_W-1:0] prev_pos,
  output logic      [POS_W-1:0] pos,
  output logic                  carry_out,
  output logic                  fill_out
);

  logic [POS_W-1:0] pos_r, pos_nxt, inc;
  logic [POS_W:0]   limit;
  logic             found;
  logic             carry_r, carry_nxt;
  logic             fill_r, fill_nxt;

  // limit for this slot: n - k + IDX + 1
  always_comb begin
    inc   = pos_r + 1'b1;
    limit = {1'b0, ctrl.nk} + (POS_W+1)'(IDX + 1);
    found = {1'b0, inc} < limit;

    pos_nxt   = pos_r;
    carry_nxt = 1'b0;
    fill_nxt  = 1'b0;
    if (ctrl.restart) begin
      pos_nxt = POS_W'(IDX);
    end else if (carry_in) begin
      pos_nxt   = inc;
      carry_nxt = !found;
      fill_nxt  = found;
    end else if (fill_in && active) begin
      pos_nxt  = prev_pos + 1'b1;
      fill_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_W'(IDX);
      carry_r <= 1'b0;
      fill_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      carry_r <= carry_nxt;
      fill_r  <= fill_nxt;
    end
  end

  assign pos       = pos_r;
  assign carry_out = carry_r;
  assign fill_out  = fill_r;

endmodule

`default_nettype wire

// File: sv/combination_tuple_generator.sv
// Lexicographic k-combination generator, top level.
// Instantiates the cgen_cell chain and the position map memory; uses cgen_pkg.
//
// Usage:
//  - Input channel (in_valid/in_ready): one transaction carries in_func,
//    in_map_index, in_map_value. func 0 restarts the walk at {0..k-1},
//    func 1 writes one map entry, func 2 emits the current tuple and advances.
//  - Output channel (out_valid/out_ready): exactly one result transaction per
//    input transaction, held in an output register until taken.
//  - Config port: cfg_we writes cfg_data into register cfg_index
//    (0 active_dims, 1 var_count, 2 use_map). Write only while idle.
//  - Sequence: restart, map load and emit-when-exhausted go straight to the
//    result. An emit with the map first reads each active slot's entry
//    through the single read port; then the carry token walks left through
//    the cell chain one cell a cycle and the refill token walks back right
//    one cell a cycle.
//  - One transaction at a time: in_ready is high only while idle.
//  - The output register frees the core, so a stalled receiver only blocks
//    once a second result is ready to be handed over.
//  - Reset (synchronous, active low): positions d = d, walk not exhausted,
//    active_dims 2, var_count 2, use_map 0. Map contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module combination_tuple_generator import cgen_pkg::*; #(
  parameter int MAX_DIM  = DEF_MAX_DIM,
  parameter int MAX_VARS = DEF_MAX_VARS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // config port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [FUNC_W-1:0]     in_func,
  input  wire logic [IDX_W-1:0]      in_map_index,
  input  wire logic [VAR_W-1:0]      in_map_value,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_tuple_valid,
  output logic                       out_more_left,
  output logic [VAR_W-1:0]           out_var_0,
  output logic [VAR_W-1:0]           out_var_1,
  output logic [VAR_W-1:0]           out_var_2,
  output logic [VAR_W-1:0]           out_var_3,
  output logic [VAR_W-1:0]           out_var_4,
  output logic [VAR_W-1:0]           out_var_5,
  output logic [VAR_W-1:0]           out_var_6,
  output logic [VAR_W-1:0]           out_var_7
);

  localparam int AW    = $clog2(MAX_VARS);
  localparam int EXT_W = 17;   // holds MAX_VARS and any position or index

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_ADV  = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  // ---------------- configuration registers ----------------
  logic [K_W-1:0] active_dims_r;
  logic [N_W-1:0] var_count_r;
  logic           use_map_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_dims_r <= K_W'(2);
      var_count_r   <= N_W'(2);
      use_map_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_DIMS: active_dims_r <= cfg_data[K_W-1:0];
        CFG_VAR_COUNT:   var_count_r   <= cfg_data[N_W-1:0];
        CFG_USE_MAP:     use_map_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective k and n after clamping.
  logic [K_W-1:0] k_eff;
  logic [N_W-1:0] n_eff;
  logic           k_le_n;
  logic [N_W-1:0] nk;

  always_comb begin
    if (active_dims_r == '0) begin
      k_eff = K_W'(1);
    end else if (active_dims_r > K_W'(MAX_DIM)) begin
      k_eff = K_W'(MAX_DIM);
    end else begin
      k_eff = active_dims_r;
    end
    if (EXT_W'(var_count_r) > EXT_W'(MAX_VARS)) begin
      n_eff = N_W'(MAX_VARS);
    end else begin
      n_eff = var_count_r;
    end
    k_le_n = N_W'(k_eff) <= n_eff;
    nk     = n_eff - N_W'(k_eff);
  end

  // ---------------- control registers ----------------
  logic [1:0]     state_r, state_nxt;
  logic [J_W-1:0] rd_j_r, rd_j_nxt;
  logic           start_r, start_nxt;
  logic           exhausted_r, exhausted_nxt;
  logic           tv_r, tv_nxt;
  logic [VAR_W-1:0] vars_r   [NUM_VARS_OUT];
  logic [VAR_W-1:0] vars_nxt [NUM_VARS_OUT];
  logic             out_valid_r, out_valid_nxt;

  logic in_accept;
  logic tuple_left;
  logic push;

  assign in_ready   = (state_r == S_IDLE);
  assign in_accept  = in_valid && in_ready;
  assign tuple_left = !exhausted_r && k_le_n;

  // ---------------- cell chain ----------------
  cell_ctrl_t       ctrl;
  logic [MAX_DIM-1:0] active_mask, last_mask;
  logic [MAX_DIM-1:0] carry_in_v, carry_out_v, fill_in_v, fill_out_v;
  logic [POS_W-1:0] pos      [MAX_DIM];
  logic [POS_W-1:0] prev_pos [MAX_DIM];
  logic             exhaust_hit, adv_done;

  assign ctrl.restart = in_accept && (in_func == FUNC_RESTART);
  assign ctrl.nk      = nk;

  for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
    assign active_mask[i] = K_W'(i) < k_eff;
    assign last_mask[i]   = K_W'(i + 1) == k_eff;

    // carry token enters at the last active cell and walks left
    if (i + 1 < MAX_DIM) begin : g_carry
      assign carry_in_v[i] = (start_r && last_mask[i]) || carry_out_v[i+1];
    end else begin : g_carry_end
      assign carry_in_v[i] = start_r && last_mask[i];
    end

    // refill token walks right, each cell takes predecessor plus one
    if (i > 0) begin : g_fill
      assign fill_in_v[i] = fill_out_v[i-1];
      assign prev_pos[i]  = pos[i-1];
    end else begin : g_fill_head
      assign fill_in_v[i] = 1'b0;
      assign prev_pos[i]  = '0;
    end

    cgen_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .active    (active_mask[i]),
      .carry_in  (carry_in_v[i]),
      .fill_in   (fill_in_v[i]),
      .prev_pos  (prev_pos[i]),
      .pos       (pos[i]),
      .carry_out (carry_out_v[i]),
      .fill_out  (fill_out_v[i])
    );
  end

  // carry falling off the left end: no position can rise
  assign exhaust_hit = carry_out_v[0];
  // last active cell settled: found there or refilled
  assign adv_done    = |(fill_out_v & last_mask);

  // ---------------- map memory ----------------
  logic [VAR_W-1:0] map_mem [MAX_VARS];
  logic [EXT_W-1:0] wr_ext, rd_ext;
  logic [POS_W-1:0] pos_sel;
  logic             map_we, rd_en, rd_oob;
  logic [VAR_W-1:0] rd_data_r;
  logic             rd_pend_r;
  logic             rd_oob_r;
  logic [J_W-1:0]   rd_slot_r;

  always_comb begin
    pos_sel = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      if (rd_j_r == J_W'(i)) pos_sel = pos[i];
    end
  end

  assign wr_ext = EXT_W'(in_map_index);
  assign rd_ext = EXT_W'(pos_sel);
  assign map_we = in_accept && (in_func == FUNC_LOAD_MAP) && (wr_ext < EXT_W'(MAX_VARS));
  assign rd_en  = (state_r == S_READ);
  assign rd_oob = rd_ext >= EXT_W'(MAX_VARS);

  always_ff @(posedge clk) begin
    if (map_we) map_mem[wr_ext[AW-1:0]] <= in_map_value;
    if (rd_en)  rd_data_r <= map_mem[rd_ext[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    rd_oob_r  <= rd_oob;
    rd_slot_r <= rd_j_r;
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt     = state_r;
    rd_j_nxt      = rd_j_r;
    start_nxt     = 1'b0;
    exhausted_nxt = exhausted_r;
    tv_nxt        = tv_r;
    vars_nxt      = vars_r;

    // map read data lands in the cycle after its address
    if (rd_pend_r) vars_nxt[rd_slot_r] = rd_oob_r ? '0 : rd_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          for (int j = 0; j < NUM_VARS_OUT; j++) vars_nxt[j] = '0;
          tv_nxt    = 1'b0;
          state_nxt = S_PUSH;
          case (in_func)
            FUNC_RESTART: exhausted_nxt = 1'b0;
            FUNC_EMIT: begin
              if (tuple_left) begin
                tv_nxt = 1'b1;
                if (use_map_r) begin
                  rd_j_nxt  = '0;
                  state_nxt = S_READ;
                end else begin
                  for (int j = 0; j < MAX_DIM; j++) begin
                    if (active_mask[j]) vars_nxt[j] = VAR_W'(pos[j]);
                  end
                  start_nxt = 1'b1;
                  state_nxt = S_ADV;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (K_W'(rd_j_r) + K_W'(1) == k_eff) begin
          start_nxt = 1'b1;
          state_nxt = S_ADV;
        end else begin
          rd_j_nxt = rd_j_r + 1'b1;
        end
      end
      S_ADV: begin
        if (exhaust_hit) begin
          exhausted_nxt = 1'b1;
          state_nxt     = S_PUSH;
        end else if (adv_done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_j_r      <= '0;
      start_r     <= 1'b0;
      exhausted_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_j_r      <= rd_j_nxt;
      start_r     <= start_nxt;
      exhausted_r <= exhausted_nxt;
      rd_pend_r   <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    tv_r   <= tv_nxt;
    vars_r <= vars_nxt;
  end

  // ---------------- output register ----------------
  logic             out_tv_r;
  logic             out_ml_r;
  logic [VAR_W-1:0] out_vars_r [NUM_VARS_OUT];

  assign push          = (state_r == S_PUSH) && (!out_valid_r || out_ready);
  assign out_valid_nxt = push || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // more_left reflects the state after this transaction
  always_ff @(posedge clk) begin
    if (push) begin
      out_tv_r   <= tv_r;
      out_ml_r   <= tuple_left;
      out_vars_r <= vars_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tuple_valid = out_tv_r;
  assign out_more_left   = out_ml_r;
  assign out_var_0       = out_vars_r[0];
  assign out_var_1       = out_vars_r[1];
  assign out_var_2       = out_vars_r[2];
  assign out_var_3       = out_vars_r[3];
  assign out_var_4       = out_vars_r[4];
  assign out_var_5       = out_vars_r[5];
  assign out_var_6       = out_vars_r[6];
  assign out_var_7       = out_vars_r[7];

endmodule

`default_nettype wire

// File: sv/cgen_chk.sv
// Port-level assertions for the combination tuple generator, plus bind.
// Depends on cgen_pkg and combination_tuple_generator.
`timescale 1ns / 1ps
`default_nettype none

module cgen_chk import cgen_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             out_tuple_valid,
  input wire logic             out_more_left,
  input wire logic [VAR_W-1:0] out_var_0,
  input wire logic [VAR_W-1:0] out_var_1,
  input wire logic [VAR_W-1:0] out_var_2,
  input wire logic [VAR_W-1:0] out_var_3,
  input wire logic [VAR_W-1:0] out_var_4,
  input wire logic [VAR_W-1:0] out_var_5,
  input wire logic [VAR_W-1:0] out_var_6,
  input wire logic [VAR_W-1:0] out_var_7
);

  // one transaction in flight: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high in the cycle after an accept");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tuple_valid) &&
      $stable(out_more_left) && $stable(out_var_0) && $stable(out_var_1) &&
      $stable(out_var_2) && $stable(out_var_3) && $stable(out_var_4) &&
      $stable(out_var_5) && $stable(out_var_6) && $stable(out_var_7))
    else $error("stalled result changed");

  // results without a tuple carry zero variables
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tuple_valid |->
      out_var_0 == '0 && out_var_1 == '0 && out_var_2 == '0 && out_var_3 == '0 &&
      out_var_4 == '0 && out_var_5 == '0 && out_var_6 == '0 && out_var_7 == '0)
    else $error("non-tuple result has nonzero variables");

  // nothing presented right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

endmodule

bind combination_tuple_generator cgen_chk u_cgen_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_tuple_valid (out_tuple_valid),
  .out_more_left   (out_more_left),
  .out_var_0       (out_var_0),
  .out_var_1       (out_var_1),
  .out_var_2       (out_var_2),
  .out_var_3       (out_var_3),
  .out_var_4       (out_var_4),
  .out_var_5       (out_var_5),
  .out_var_6       (out_var_6),
  .out_var_7       (out_var_7)
);

`default_nettype wire
